// ----- src/ufd_pkg.sv -----
// ----------------------------------------------------------------------------
// ufd_pkg
// Shared types, constants and helpers of the form-encoded string decoder.
// ----------------------------------------------------------------------------
package ufd_pkg;

  typedef struct packed {
    logic [7:0] in_char;
    logic       final_char;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       run_last;
    logic       input_end;
  } out_item_t;

  localparam int unsigned MaxResults = 3;

  typedef struct packed {
    logic [1:0]                 cnt;
    out_item_t [MaxResults-1:0] item;
  } res_list_t;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_BAD  = 2'd2;

  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_AMP   = 8'h26;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] BYTE_LF    = 8'h0A;

  typedef enum logic [6:0] {
    M_IDLE     = 7'b0000001,
    M_ESC1     = 7'b0000010,
    M_ESC2_OK  = 7'b0000100,
    M_ESC2_BAD = 7'b0001000,
    M_CR       = 7'b0010000,
    M_CR_PCT   = 7'b0100000,
    M_CR_PCT1  = 7'b1000000
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic [3:0] nib;
  } dec_state_t;

  // Returns {is_hex, value} for one character.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic out_item_t mk_item(input logic [7:0] b, input logic [1:0] k,
                                        input logic e);
    out_item_t r;
    r.out_byte  = b;
    r.kind      = k;
    r.run_last  = 1'b0;
    r.input_end = e;
    return r;
  endfunction

endpackage

// ----- src/ufd_decode.sv -----
// ----------------------------------------------------------------------------
// ufd_decode
// Next decode state and result list for one character.
// ----------------------------------------------------------------------------
module ufd_decode (
  input  ufd_pkg::in_item_t   item_i,
  input  ufd_pkg::dec_state_t state_i,
  output ufd_pkg::dec_state_t state_o,
  output ufd_pkg::res_list_t  list_o
);
  import ufd_pkg::*;

  localparam int unsigned NumCand = 5;

  logic [7:0]               c;
  logic                     fin;
  logic [4:0]               hx;
  logic                     h_ok;
  logic [7:0]               v;
  logic                     plain_v;
  out_item_t                plain_item;
  mode_t                    mode_mid;
  logic [3:0]               nib_mid;
  out_item_t [NumCand-1:0]  cand;
  logic [NumCand-1:0]       cand_v;
  logic [1:0]               n;

  always_comb begin
    c       = item_i.in_char;
    fin     = item_i.final_char;
    hx      = hex_value(c);
    h_ok    = hx[4];
    v       = {state_i.nib, hx[3:0]};
    plain_v = (c != CHAR_PCT);
    if (c == CHAR_PLUS) begin
      plain_item = mk_item(CHAR_SPACE, KIND_BYTE, 1'b0);
    end else if (c == CHAR_AMP) begin
      plain_item = mk_item(8'd0, KIND_END, 1'b0);
    end else begin
      plain_item = mk_item(c, KIND_BYTE, 1'b0);
    end

    cand     = '0;
    cand_v   = '0;
    mode_mid = state_i.mode;
    nib_mid  = state_i.nib;

    unique case (state_i.mode)
      M_ESC1: begin
        if (h_ok) begin
          nib_mid  = hx[3:0];
          mode_mid = M_ESC2_OK;
        end else begin
          mode_mid = M_ESC2_BAD;
        end
      end
      M_ESC2_OK: begin
        mode_mid = M_IDLE;
        if (h_ok) begin
          if (v == BYTE_CR) begin
            mode_mid = M_CR;
          end else begin
            cand[0] = mk_item(v, KIND_BYTE, 1'b0);
            cand_v[0] = 1'b1;
          end
        end else begin
          cand[0] = mk_item(8'd0, KIND_BAD, 1'b0);
          cand_v[0] = 1'b1;
        end
      end
      M_ESC2_BAD: begin
        mode_mid = M_IDLE;
        cand[0] = mk_item(8'd0, KIND_BAD, 1'b0);
        cand_v[0] = 1'b1;
      end
      M_CR: begin
        if (c == CHAR_PCT) begin
          mode_mid = M_CR_PCT;
        end else begin
          mode_mid = M_IDLE;
          cand[0] = mk_item(BYTE_CR, KIND_BYTE, 1'b0);
          cand_v[0] = 1'b1;
          cand[1] = plain_item;
          cand_v[1] = 1'b1;
        end
      end
      M_CR_PCT: begin
        if (h_ok) begin
          nib_mid  = hx[3:0];
          mode_mid = M_CR_PCT1;
        end else begin
          mode_mid = M_ESC2_BAD;
          cand[0] = mk_item(BYTE_CR, KIND_BYTE, 1'b0);
          cand_v[0] = 1'b1;
        end
      end
      M_CR_PCT1: begin
        mode_mid = M_IDLE;
        cand_v[0] = 1'b1;
        if (h_ok && v == BYTE_LF) begin
          cand[0] = mk_item(BYTE_LF, KIND_BYTE, 1'b0);
        end else begin
          cand[0] = mk_item(BYTE_CR, KIND_BYTE, 1'b0);
          if (!h_ok) begin
            cand[1] = mk_item(8'd0, KIND_BAD, 1'b0);
            cand_v[1] = 1'b1;
          end else if (v == BYTE_CR) begin
            mode_mid = M_CR;
          end else begin
            cand[1] = mk_item(v, KIND_BYTE, 1'b0);
            cand_v[1] = 1'b1;
          end
        end
      end
      default: begin
        mode_mid = plain_v ? M_IDLE : M_ESC1;
        cand[0] = plain_item;
        cand_v[0] = plain_v;
      end
    endcase

    state_o.mode = mode_mid;
    state_o.nib  = nib_mid;

    if (fin) begin
      unique case (mode_mid) inside
        M_ESC1, M_ESC2_OK, M_ESC2_BAD: begin
          cand[2] = mk_item(8'd0, KIND_BAD, 1'b0);
          cand_v[2] = 1'b1;
        end
        M_CR: begin
          cand[2] = mk_item(BYTE_CR, KIND_BYTE, 1'b0);
          cand_v[2] = 1'b1;
        end
        M_CR_PCT, M_CR_PCT1: begin
          cand[2] = mk_item(BYTE_CR, KIND_BYTE, 1'b0);
          cand_v[2] = 1'b1;
          cand[3] = mk_item(8'd0, KIND_BAD, 1'b0);
          cand_v[3] = 1'b1;
        end
        default: begin
        end
      endcase
      cand[4] = mk_item(8'd0, KIND_END, 1'b1);
      cand_v[4] = 1'b1;
      state_o.mode = M_IDLE;
      state_o.nib  = 4'd0;
    end

    list_o = '0;
    n = 2'd0;
    for (int i = 0; i < NumCand; i++) begin
      if (cand_v[i] && n != 2'd3) begin
        list_o.item[n] = cand[i];
        n = n + 2'd1;
      end
    end
    if (n != 2'd0) begin
      list_o.item[n - 2'd1].run_last = 1'b1;
    end
    list_o.cnt = n;
  end

endmodule

// ----- src/ufd_result_buf.sv -----
// ----------------------------------------------------------------------------
// ufd_result_buf
// Holds the results of one character and hands them out one per transfer.
// ----------------------------------------------------------------------------
module ufd_result_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load_i,
  input  ufd_pkg::res_list_t  list_i,
  output logic                free_o,
  output logic                out_valid,
  input  logic                out_ready,
  output ufd_pkg::out_item_t  out_data
);
  import ufd_pkg::*;

  out_item_t [MaxResults-1:0] list_r;
  logic [1:0]                 rem_r;
  logic                       take;

  assign out_valid = (rem_r != 2'd0);
  assign out_data  = list_r[0];
  assign take      = out_valid && out_ready;
  assign free_o    = (rem_r == 2'd0) || (rem_r == 2'd1 && out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 2'd0;
    end else if (load_i) begin
      rem_r <= list_i.cnt;
    end else if (take) begin
      rem_r <= rem_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      list_r <= list_i.item;
    end else if (take) begin
      list_r[0] <= list_r[1];
      list_r[1] <= list_r[2];
    end
  end

endmodule

// ----- src/url_form_decoder.sv -----
// ----------------------------------------------------------------------------
// url_form_decoder
// Form-encoded string decoder: one raw character in, zero to three results out.
// ----------------------------------------------------------------------------
// The input channel carries one raw character per transfer with a flag on the
// last character of a string. The result channel carries decoded bytes, field
// ends and flags for dropped malformed escapes, one result per transfer, with
// run_last marking the last result of a character and input_end marking the
// field end that closes the string.
// A character is registered in the input register on acceptance and decoded
// from it; its results load into the result buffer once the buffer is free,
// which presents the first one. A new character is accepted every cycle as
// long as each yields at most one result and the receiver takes every result;
// a character with several results holds the buffer until they are taken,
// and a character with none passes through without using it.
// When the receiver stalls, the result buffer holds its contents, the input
// register fills, and in_ready drops until the buffer drains.
// Reset clears the decode state to plain characters, empties the input
// register and the result buffer, and needs no other preparation.
// ----------------------------------------------------------------------------
module url_form_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ufd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ufd_pkg::out_item_t out_data
);
  import ufd_pkg::*;

  logic       in_valid_r;
  in_item_t   in_data_r;
  dec_state_t state_r;
  dec_state_t state_nxt;
  res_list_t  list;
  logic       free;
  logic       dec_go;

  assign dec_go   = in_valid_r && free;
  assign in_ready = !in_valid_r || free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (dec_go) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode <= M_IDLE;
      state_r.nib  <= 4'd0;
    end else if (dec_go) begin
      state_r <= state_nxt;
    end
  end

  ufd_decode u_decode (
    .item_i  (in_data_r),
    .state_i (state_r),
    .state_o (state_nxt),
    .list_o  (list)
  );

  ufd_result_buf u_result_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_i    (dec_go),
    .list_i    (list),
    .free_o    (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- src/ufd_checker.sv -----
// ----------------------------------------------------------------------------
// ufd_checker
// Port-level checks of the decoder's result channel.
// ----------------------------------------------------------------------------
module ufd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input ufd_pkg::out_item_t out_data
);
  import ufd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or vanished while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result presented right after reset");

  a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.input_end |-> out_data.kind == KIND_END && out_data.run_last)
    else $error("closing field end is not the last result of its character");

  a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.kind == KIND_BYTE || out_data.kind == KIND_END ||
                  out_data.kind == KIND_BAD)
    else $error("result kind code out of range");

  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != KIND_BYTE |-> out_data.out_byte == 8'd0)
    else $error("non-data result carries a byte");

endmodule

bind url_form_decoder ufd_checker u_ufd_checker (.*);

// ----- sim/url_form_decoder_chk.sv -----
// ----------------------------------------------------------------------------
// url_form_decoder_chk
// Result checker for the form-encoded string decoder.
// ----------------------------------------------------------------------------
// Watches both channels of the decoder. Every accepted character runs through
// a cycle-free decoder of its own, which queues the results that the character
// must produce. Every accepted result is compared against the oldest queued
// result; unexpected and wrong results are counted as failures. The failure
// count and the number of results still awaited go to the testbench top.
// ----------------------------------------------------------------------------
module url_form_decoder_chk (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  ufd_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  ufd_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 pending
);
  import ufd_pkg::*;

  mode_t      mode;
  logic [3:0] hi_nib;
  out_item_t  burst[$];
  out_item_t  want_q[$];
  int         errs = 0;

  // Bit 4 is set when the character is a hex digit; bits 3:0 hold its value.
  function automatic logic [4:0] hex_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      return {1'b1, d[3:0]};
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      return {1'b1, d[3:0]};
    end
    if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

  task automatic emit(input logic [7:0] b, input logic [1:0] k, input logic e);
    out_item_t r;
    r.out_byte  = b;
    r.kind      = k;
    r.run_last  = 1'b0;
    r.input_end = e;
    if (burst.size() < MaxResults) begin
      burst.push_back(r);
    end
  endtask

  task automatic take_plain(input logic [7:0] c);
    if (c == CHAR_PCT) begin
      mode = M_ESC1;
    end else if (c == CHAR_PLUS) begin
      emit(CHAR_SPACE, KIND_BYTE, 1'b0);
    end else if (c == CHAR_AMP) begin
      emit(8'h00, KIND_END, 1'b0);
    end else begin
      emit(c, KIND_BYTE, 1'b0);
    end
  endtask

  task automatic decode_char(input in_item_t it);
    logic [4:0] h;
    logic [7:0] v;
    out_item_t  r;
    burst.delete();
    h = hex_of(it.in_char);
    v = {hi_nib, h[3:0]};
    case (mode)
      M_ESC1: begin
        if (h[4]) begin
          hi_nib = h[3:0];
          mode   = M_ESC2_OK;
        end else begin
          mode = M_ESC2_BAD;
        end
      end
      M_ESC2_OK: begin
        mode = M_IDLE;
        if (h[4]) begin
          if (v == BYTE_CR) mode = M_CR;
          else emit(v, KIND_BYTE, 1'b0);
        end else begin
          emit(8'h00, KIND_BAD, 1'b0);
        end
      end
      M_ESC2_BAD: begin
        mode = M_IDLE;
        emit(8'h00, KIND_BAD, 1'b0);
      end
      M_CR: begin
        if (it.in_char == CHAR_PCT) begin
          mode = M_CR_PCT;
        end else begin
          mode = M_IDLE;
          emit(BYTE_CR, KIND_BYTE, 1'b0);
          take_plain(it.in_char);
        end
      end
      M_CR_PCT: begin
        if (h[4]) begin
          hi_nib = h[3:0];
          mode   = M_CR_PCT1;
        end else begin
          emit(BYTE_CR, KIND_BYTE, 1'b0);
          mode = M_ESC2_BAD;
        end
      end
      M_CR_PCT1: begin
        mode = M_IDLE;
        if (h[4]) begin
          if (v == BYTE_LF) begin
            emit(BYTE_LF, KIND_BYTE, 1'b0);
          end else begin
            emit(BYTE_CR, KIND_BYTE, 1'b0);
            if (v == BYTE_CR) mode = M_CR;
            else emit(v, KIND_BYTE, 1'b0);
          end
        end else begin
          emit(BYTE_CR, KIND_BYTE, 1'b0);
          emit(8'h00, KIND_BAD, 1'b0);
        end
      end
      default: begin
        mode = M_IDLE;
        take_plain(it.in_char);
      end
    endcase
    if (it.final_char) begin
      case (mode)
        M_ESC1, M_ESC2_OK, M_ESC2_BAD: begin
          emit(8'h00, KIND_BAD, 1'b0);
        end
        M_CR: begin
          emit(BYTE_CR, KIND_BYTE, 1'b0);
        end
        M_CR_PCT, M_CR_PCT1: begin
          emit(BYTE_CR, KIND_BYTE, 1'b0);
          emit(8'h00, KIND_BAD, 1'b0);
        end
        default: begin
        end
      endcase
      emit(8'h00, KIND_END, 1'b1);
      mode   = M_IDLE;
      hi_nib = 4'h0;
    end
    foreach (burst[i]) begin
      r          = burst[i];
      r.run_last = (i == burst.size() - 1);
      want_q.push_back(r);
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t got;
    out_item_t want;
    if (!rst_n) begin
      mode   = M_IDLE;
      hi_nib = 4'h0;
      want_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        decode_char(in_data);
      end
      if (out_valid && out_ready) begin
        got = out_data;
        if (want_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected result byte=%h kind=%0d last=%b end=%b", $time,
                   got.out_byte, got.kind, got.run_last, got.input_end);
        end else begin
          want = want_q.pop_front();
          if (got.out_byte !== want.out_byte || got.kind !== want.kind ||
              got.run_last !== want.run_last || got.input_end !== want.input_end) begin
            errs++;
            $display("%0t: expected byte=%h kind=%0d last=%b end=%b, got byte=%h kind=%0d last=%b end=%b",
                     $time, want.out_byte, want.kind, want.run_last, want.input_end,
                     got.out_byte, got.kind, got.run_last, got.input_end);
          end
        end
      end
    end
    fail_count <= errs;
    pending    <= want_q.size();
  end

endmodule

// ----- sim/url_form_decoder_tb.sv -----
// ----------------------------------------------------------------------------
// url_form_decoder_tb
// Testbench top for the form-encoded string decoder.
// ----------------------------------------------------------------------------
// Drives a short directed string set and then random escape-heavy strings
// into the decoder under three idling profiles, holds the result channel off
// once so the input stalls, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module url_form_decoder_tb;
  import ufd_pkg::*;

  localparam int StallLimit  = 1000;
  localparam int HoldCycles  = 80;
  localparam int RandomItems = 250;
  localparam int TailCycles  = 10;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  int        fail_count;
  int        pending;

  int        send_idle = 19;
  int        recv_idle = 76;
  logic      pressure  = 1'b0;
  int        hold_left = 0;
  logic      hold_done = 1'b0;
  int        quiet     = 0;
  logic [7:0] tok[$];

  always #2 clk = ~clk;

  url_form_decoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  url_form_decoder_chk u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (pressure && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= StallLimit) begin
      $display("url_form_decoder_tb NOT OK");
      $finish;
    end
  end

  task automatic send_char(input logic [7:0] c, input logic fin);
    in_item_t t;
    t.in_char    = c;
    t.final_char = fin;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_text(input string s, input logic fin_last);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], fin_last && (i == s.len() - 1));
    end
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v, input logic lower);
    if (v < 4'd10) return 8'h30 + v;
    return (lower ? 8'h61 : 8'h41) + v - 8'd10;
  endfunction

  function automatic logic [7:0] rand_hex();
    return hex_char(4'($urandom_range(15)), 1'($urandom_range(1)));
  endfunction

  function automatic logic [7:0] non_hex();
    case ($urandom_range(3))
      0: return CHAR_AMP;
      1: return CHAR_PLUS;
      2: return CHAR_PCT;
      default: return 8'($urandom_range(8'h47, 8'h60));
    endcase
  endfunction

  // Pushes the escape "%0D" with a random case for the D.
  task automatic push_cr_escape();
    tok.push_back(CHAR_PCT);
    tok.push_back(8'h30);
    tok.push_back(hex_char(4'hD, 1'($urandom_range(1))));
  endtask

  task automatic make_token();
    tok.delete();
    case ($urandom_range(11))
      0, 1, 2: tok.push_back(8'($urandom_range(255)));
      3: tok.push_back(CHAR_PLUS);
      4: tok.push_back(CHAR_AMP);
      5, 6: begin
        tok.push_back(CHAR_PCT);
        tok.push_back(rand_hex());
        tok.push_back(rand_hex());
      end
      7: begin
        push_cr_escape();
        tok.push_back(CHAR_PCT);
        tok.push_back(8'h30);
        tok.push_back(hex_char(4'hA, 1'($urandom_range(1))));
      end
      8: begin
        push_cr_escape();
        case ($urandom_range(2))
          0: tok.push_back(8'($urandom_range(255)));
          1: begin
            tok.push_back(CHAR_PCT);
            tok.push_back(rand_hex());
            tok.push_back(rand_hex());
          end
          default: push_cr_escape();
        endcase
      end
      9: begin
        tok.push_back(CHAR_PCT);
        if ($urandom_range(1)) begin
          tok.push_back(non_hex());
          tok.push_back(8'($urandom_range(255)));
        end else begin
          tok.push_back(rand_hex());
          tok.push_back(non_hex());
        end
      end
      10: begin
        push_cr_escape();
        tok.push_back(CHAR_PCT);
        if ($urandom_range(1)) begin
          tok.push_back(non_hex());
        end else begin
          tok.push_back(rand_hex());
          tok.push_back(non_hex());
        end
      end
      default: begin
        push_cr_escape();
        tok.push_back(CHAR_PCT);
        tok.push_back(rand_hex());
        tok.push_back(rand_hex());
      end
    endcase
  endtask

  initial begin : stimulus
    int sent;
    int phase;
    sent  = 0;
    phase = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_text("+&", 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_text("%4a", 1'b0);
    send_text("%0D%0A", 1'b0);
    send_text("%0D%%1", 1'b0);
    send_text("%G&", 1'b0);
    send_text("%0D%0", 1'b1);

    while (sent < RandomItems) begin
      if (phase == 0 && sent >= RandomItems / 3) begin
        phase     = 1;
        send_idle = 76;
        recv_idle <= 19;
      end
      if (phase == 1 && sent >= 2 * RandomItems / 3) begin
        phase     = 2;
        send_idle = 0;
        recv_idle <= 0;
        pressure  <= 1'b1;
      end
      make_token();
      foreach (tok[i]) begin
        send_char(tok[i], $urandom_range(19) == 0);
        sent++;
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("url_form_decoder_tb OK");
    end else begin
      $display("url_form_decoder_tb NOT OK");
    end
    $finish;
  end

endmodule
